@@ sv/hcb_pkg.sv @@
// shared types and constants of the huffman code builder
package hcb_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int NODE_W      = $clog2(NODE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int FREQ_W      = 24;
  localparam int WEIGHT_W    = 30;
  localparam int CODE_W      = 63;
  localparam int LEN_W       = 6;
  localparam int INDEX_W     = 6;

  // heap entry: weight kept next to the node number
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   id;
  } heap_entry_t;

  // request from the controller to the heap unit
  typedef struct packed {
    logic        push;
    logic        pop;
    heap_entry_t entry;
  } heap_cmd_t;

  // status of the heap unit
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
    heap_entry_t      top;
  } heap_stat_t;

  // preorder walk stack entry
  typedef struct packed {
    logic [NODE_W-1:0] id;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } walk_entry_t;

endpackage

@@ sv/hcb_if.sv @@
// valid/ready channel interfaces for symbol requests and code results
interface hcb_in_if import hcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic              last_symbol;

  modport source (output valid, frequency, last_symbol, input ready);
  modport sink (input valid, frequency, last_symbol, output ready);
endinterface

interface hcb_out_if import hcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] symbol_index;
  logic [CODE_W-1:0]  code_bits;
  logic [LEN_W-1:0]   code_length;
  logic               last_code;

  modport source (output valid, symbol_index, code_bits, code_length, last_code, input ready);
  modport sink (input valid, symbol_index, code_bits, code_length, last_code, output ready);
endinterface

@@ sv/hcb_heap.sv @@
// binary min-heap unit: slot memory with sift-up and sift-down sequencer
module hcb_heap import hcb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  heap_cmd_t  cmd,
  output heap_stat_t stat
);

  typedef enum logic [2:0] {
    H_IDLE, H_UP_RD, H_UP_CMP, H_POP_TOP, H_POP_LAST, H_DN_RD, H_DN_CMP
  } hstate_t;

  hstate_t          state;
  logic [CNT_W-1:0] cnt;
  logic [SYM_W-1:0] pos;
  heap_entry_t      cur;
  heap_entry_t      top;

  heap_entry_t      slots [MAX_SYMBOLS];
  heap_entry_t      rdata0, rdata1, wdata;
  logic [SYM_W-1:0] raddr0, raddr1;
  logic             we;

  logic [SYM_W:0]   l_idx;
  logic [SYM_W+1:0] r_idx;
  logic [SYM_W-1:0] parent;
  logic [CNT_W-1:0] cnt_m1;
  logic             up_stop, take_l, take_r;
  logic [WEIGHT_W-1:0] min_w;

  // child and parent positions of the hole
  assign l_idx  = {pos, 1'b1};
  assign r_idx  = {1'b0, pos, 1'b0} + (SYM_W+2)'(2);
  assign parent = (pos - SYM_W'(1)) >> 1;
  assign cnt_m1 = cnt - CNT_W'(1);

  // compares: shift-up stops on less-or-equal, shift-down takes strictly smaller
  assign up_stop = rdata0.weight <= cur.weight;
  assign take_l  = (l_idx < cnt) && (rdata0.weight < cur.weight);
  assign min_w   = take_l ? rdata0.weight : cur.weight;
  assign take_r  = (r_idx < {1'b0, cnt}) && (rdata1.weight < min_w);

  // memory addresses and write data
  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    we     = 1'b0;
    wdata  = cur;
    unique case (state)
      H_IDLE: raddr0 = '0;
      H_UP_RD: begin
        raddr0 = parent;
        we     = (pos == '0);
      end
      H_UP_CMP: begin
        we    = 1'b1;
        wdata = up_stop ? cur : rdata0;
      end
      H_POP_TOP: raddr0 = cnt_m1[SYM_W-1:0];
      H_POP_LAST: raddr0 = '0;
      H_DN_RD: begin
        raddr0 = l_idx[SYM_W-1:0];
        raddr1 = r_idx[SYM_W-1:0];
      end
      H_DN_CMP: begin
        we    = 1'b1;
        wdata = take_r ? rdata1 : (take_l ? rdata0 : cur);
      end
      default: we = 1'b0;
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) slots[pos] <= wdata;
    rdata0 <= slots[raddr0];
    rdata1 <= slots[raddr1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (cmd.push && (cnt < CNT_W'(MAX_SYMBOLS))) begin
            cur   <= cmd.entry;
            pos   <= cnt[SYM_W-1:0];
            cnt   <= cnt + CNT_W'(1);
            state <= H_UP_RD;
          end else if (cmd.pop) begin
            state <= H_POP_TOP;
          end
        end
        H_UP_RD: state <= (pos == '0) ? H_IDLE : H_UP_CMP;
        H_UP_CMP: begin
          if (up_stop) begin
            state <= H_IDLE;
          end else begin
            pos   <= parent;
            state <= H_UP_RD;
          end
        end
        H_POP_TOP: begin
          top   <= rdata0;
          cnt   <= cnt_m1;
          state <= H_POP_LAST;
        end
        H_POP_LAST: begin
          cur   <= rdata0;
          pos   <= '0;
          state <= (cnt == '0) ? H_IDLE : H_DN_RD;
        end
        H_DN_RD: state <= H_DN_CMP;
        H_DN_CMP: begin
          priority if (take_r) begin
            pos   <= r_idx[SYM_W-1:0];
            state <= H_DN_RD;
          end else if (take_l) begin
            pos   <= l_idx[SYM_W-1:0];
            state <= H_DN_RD;
          end else begin
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign stat.busy  = (state != H_IDLE);
  assign stat.count = cnt;
  assign stat.top   = top;

endmodule

@@ sv/huffman_code_builder_core.sv @@
// huffman code builder top level: leaf store, merge control, tree store and preorder walk
//
//  channel   | dir | payload                                           | request
//  sym_in    | in  | frequency, last_symbol                            | one symbol weight
//  code_out  | out | symbol_index, code_bits, code_length, last_code   | one leaf code
//
// loading accepts one request per cycle; a set of n symbols is then pushed into the heap,
// merged pairwise through the single heap sequencer, and walked in preorder, a leaf through
// S_W_POP and S_W_CHK and an internal node through these and then S_W_KID and S_W_KID2.
// reset is synchronous; no memory needs clearing, the heap count and the symbol count are the fill marks.
// a stalled code_out holds the walk; sym_in is ready only while loading.
module huffman_code_builder_core import hcb_pkg::*; (
  input logic       clk,
  input logic       rst,
  hcb_in_if.sink    sym_in,
  hcb_out_if.source code_out
);

  typedef enum logic [3:0] {
    S_LOAD, S_B_RD, S_B_PUSH, S_B_WAIT, S_M_CHK, S_M_W1, S_M_W2,
    S_R_W, S_W_POP, S_W_CHK, S_W_KID, S_W_KID2
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  sym_cnt;
  logic [CNT_W-1:0]  n_sym;
  logic [SYM_W-1:0]  idx;
  logic [NODE_W-1:0] next_id;
  logic [CNT_W-1:0]  sp;
  heap_entry_t       lnode;

  heap_cmd_t  hcmd;
  heap_stat_t hstat;

  // memories
  logic [FREQ_W-1:0]   leaf_mem [MAX_SYMBOLS];
  logic [2*NODE_W-1:0] kid_mem  [NODE_DEPTH];
  walk_entry_t         stack_mem [MAX_SYMBOLS];
  logic [FREQ_W-1:0]   leaf_rd;
  logic [2*NODE_W-1:0] kid_rd;
  walk_entry_t         stack_rd;

  logic              accept, fits, stack_we, stack_re, kid_re;
  logic [SYM_W-1:0]  stack_waddr;
  walk_entry_t       stack_wdata;
  logic              is_leaf, can_split, out_free, emit;
  logic [CODE_W-1:0] shifted;

  // output register
  logic               o_valid;
  logic [INDEX_W-1:0] o_index;
  logic [CODE_W-1:0]  o_bits;
  logic [LEN_W-1:0]   o_len;
  logic               o_last;

  assign accept    = sym_in.valid && sym_in.ready;
  assign fits      = sym_cnt < CNT_W'(MAX_SYMBOLS);
  assign is_leaf   = {1'b0, stack_rd.id} < {1'b0, n_sym};
  assign can_split = ({1'b0, sp} + (CNT_W+1)'(2) <= (CNT_W+1)'(MAX_SYMBOLS))
                     && (stack_rd.len < LEN_W'(CODE_W));
  assign out_free  = !o_valid || code_out.ready;
  assign shifted   = stack_rd.bits << 1;

  // a leaf code moves into the output register
  assign emit      = (state == S_W_CHK) && is_leaf && out_free;

  heap_entry_t push_entry;
  assign push_entry.weight = lnode.weight + hstat.top.weight;
  assign push_entry.id     = next_id;

  // heap requests, walk stack writes, and walk stack and child memory reads
  always_comb begin
    hcmd        = '0;
    stack_we    = 1'b0;
    stack_waddr = sp[SYM_W-1:0];
    stack_wdata = stack_rd;
    stack_re    = 1'b0;
    kid_re      = 1'b0;
    unique case (state)
      S_B_PUSH: begin
        hcmd.push         = 1'b1;
        hcmd.entry.weight = WEIGHT_W'(leaf_rd);
        hcmd.entry.id     = NODE_W'(idx);
      end
      S_M_CHK: hcmd.pop = !hstat.busy;
      S_M_W1:  hcmd.pop = !hstat.busy;
      S_M_W2: begin
        hcmd.push  = !hstat.busy;
        hcmd.entry = push_entry;
      end
      S_R_W: begin
        stack_we         = !hstat.busy;
        stack_waddr      = '0;
        stack_wdata.id   = hstat.top.id;
        stack_wdata.bits = '0;
        stack_wdata.len  = '0;
      end
      S_W_POP: stack_re = 1'b1;
      S_W_CHK: kid_re = !is_leaf;
      S_W_KID: begin
        stack_we         = 1'b1;
        stack_wdata.id   = kid_rd[NODE_W-1:0];
        stack_wdata.bits = shifted | CODE_W'(1);
        stack_wdata.len  = stack_rd.len + LEN_W'(1);
      end
      S_W_KID2: begin
        stack_we         = 1'b1;
        stack_waddr      = sp[SYM_W-1:0] + SYM_W'(1);
        stack_wdata.id   = kid_rd[2*NODE_W-1:NODE_W];
        stack_wdata.bits = shifted;
        stack_wdata.len  = stack_rd.len + LEN_W'(1);
      end
      default: hcmd = '0;
    endcase
  end

  hcb_heap u_heap (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hcmd),
    .stat (hstat)
  );

  // leaf weight memory
  always_ff @(posedge clk) begin
    if (accept && fits) leaf_mem[sym_cnt[SYM_W-1:0]] <= sym_in.frequency;
    leaf_rd <= leaf_mem[idx];
  end

  // child memory, {left, right} per internal node
  always_ff @(posedge clk) begin
    if (state == S_M_W2 && !hstat.busy) kid_mem[next_id] <= {lnode.id, hstat.top.id};
    if (kid_re) kid_rd <= kid_mem[stack_rd.id];
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rd <= stack_mem[sp[SYM_W-1:0] - SYM_W'(1)];
  end

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      sym_cnt <= '0;
      o_valid <= 1'b0;
    end else begin
      if (emit) o_valid <= 1'b1;
      else if (code_out.ready) o_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (sym_in.last_symbol) begin
              n_sym   <= sym_cnt + CNT_W'(fits);
              next_id <= NODE_W'(sym_cnt + CNT_W'(fits));
              sym_cnt <= '0;
              idx     <= '0;
              state   <= S_B_RD;
            end else if (fits) begin
              sym_cnt <= sym_cnt + CNT_W'(1);
            end
          end
        end
        S_B_RD:   state <= S_B_PUSH;
        S_B_PUSH: state <= S_B_WAIT;
        S_B_WAIT: begin
          if (!hstat.busy) begin
            if ({1'b0, idx} == n_sym - CNT_W'(1)) begin
              state <= S_M_CHK;
            end else begin
              idx   <= idx + SYM_W'(1);
              state <= S_B_RD;
            end
          end
        end
        S_M_CHK: begin
          if (!hstat.busy) state <= (hstat.count >= CNT_W'(2)) ? S_M_W1 : S_R_W;
        end
        S_M_W1: begin
          if (!hstat.busy) begin
            lnode <= hstat.top;
            state <= S_M_W2;
          end
        end
        S_M_W2: begin
          if (!hstat.busy) begin
            next_id <= next_id + NODE_W'(1);
            state   <= S_M_CHK;
          end
        end
        S_R_W: begin
          if (!hstat.busy) begin
            sp    <= CNT_W'(1);
            state <= S_W_POP;
          end
        end
        S_W_POP: begin
          sp    <= sp - CNT_W'(1);
          state <= S_W_CHK;
        end
        S_W_CHK: begin
          priority if (is_leaf) begin
            if (out_free) begin
              o_index <= stack_rd.id[INDEX_W-1:0];
              o_bits  <= (stack_rd.len == '0) ? '0 : stack_rd.bits;
              o_len   <= (stack_rd.len == '0) ? LEN_W'(1) : stack_rd.len;
              o_last  <= (sp == '0);
              state   <= (sp == '0) ? S_LOAD : S_W_POP;
            end
          end else if (can_split) begin
            state <= S_W_KID;
          end else begin
            state <= (sp == '0) ? S_LOAD : S_W_POP;
          end
        end
        S_W_KID: state <= S_W_KID2;
        S_W_KID2: begin
          sp    <= sp + CNT_W'(2);
          state <= S_W_POP;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign sym_in.ready          = (state == S_LOAD);
  assign code_out.valid        = o_valid;
  assign code_out.symbol_index = o_index;
  assign code_out.code_bits    = o_bits;
  assign code_out.code_length  = o_len;
  assign code_out.last_code    = o_last;

endmodule

@@ sv/hcb_chk.sv @@
// port checker for the huffman code builder, bound to the top level
module hcb_chk import hcb_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] out_index,
  input logic [CODE_W-1:0]  out_bits,
  input logic [LEN_W-1:0]   out_len,
  input logic               out_last
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_bits)
                                   && $stable(out_len) && $stable(out_last)))
    else $error("result changed while stalled");

  // a code is never empty
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len != '0))
    else $error("zero code length");

  // a one-bit code has nothing above its bit
  a_one_bit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_len == LEN_W'(1)) |-> (out_bits[CODE_W-1:1] == '0))
    else $error("one-bit code has stray bits");

  // the closing symbol, once taken, ends loading
  a_build_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("still loading after closing symbol");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind huffman_code_builder_core hcb_chk u_hcb_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sym_in.valid),
  .in_ready  (sym_in.ready),
  .in_last   (sym_in.last_symbol),
  .out_valid (code_out.valid),
  .out_ready (code_out.ready),
  .out_index (code_out.symbol_index),
  .out_bits  (code_out.code_bits),
  .out_len   (code_out.code_length),
  .out_last  (code_out.last_code)
);
